[rtl/ostp_pkg.sv]
// ----------------------------------------------------------------------------
// ostp_pkg: shared constants and types for the timer pool
// Operation and result codes, slot geometry.
// ----------------------------------------------------------------------------
package ostp_pkg;
  localparam int NUM_SLOTS = 64;
  localparam int HW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_DEFER  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_GRANTED   = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_NO_HANDLE = 2'd3
  } kind_t;
endpackage

[rtl/ostp_ram.sv]
// ----------------------------------------------------------------------------
// ostp_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ostp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/one_shot_timer_pool_with_handles_top.sv]
// ----------------------------------------------------------------------------
// one_shot_timer_pool_with_handles_top: pool of one-shot timers with handles
// Defer grants a handle, cancel/clear free handles, tick fires expired timers.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid, in_stall, operation, delay_ms,       | into block
//          | target_handle, elapsed_ms                      |
//  out     | out_valid, out_stall, kind, handle, last       | out of block
//
// Defer from the fresh counter and cancel put their result out in the cycle
// after the transfer; a defer from the free FIFO first does a FIFO read, then
// the slot write. Clear and tick scan every slot, one slot a cycle through the
// start/duration memory read port while no fired result waits on a stalled
// output; the last result comes from the flush state. One item is worked on
// at a time. Reset is synchronous; live bits sit in flip-flops and clear at
// once, so no clearing pass is needed. A stalled output also holds the flush.
module one_shot_timer_pool_with_handles_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [30:0] delay_ms,
  input  logic [5:0]  target_handle,
  input  logic [15:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [5:0]  handle,
  output logic        last
);
  localparam int HW = ostp_pkg::HW;
  localparam int N  = ostp_pkg::NUM_SLOTS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010, // free FIFO read in flight
    S_SCAN  = 5'b00100, // issue slot reads
    S_EVAL  = 5'b01000, // compare data of previous read
    S_FLUSH = 5'b10000  // tail of scan, emit pending result
  } state_t;

  state_t state;
  logic [N-1:0] live;
  logic [31:0] cur_time;
  logic [HW:0] fresh_cnt;
  logic        fresh_ex;
  logic [HW-1:0] f_head, f_tail;
  logic [HW:0]   f_count;
  logic [1:0]  op;
  logic [30:0] dly;
  logic [HW:0] scan_idx;     // next slot to read
  logic [HW-1:0] eval_idx;   // slot whose data is on rdata
  logic        eval_vld;
  logic        have_pend;    // a fired result is held back to learn last
  logic [HW-1:0] pend_h;

  // slot memory: {start, duration}
  logic         s_we;
  logic [HW-1:0] s_waddr, s_raddr;
  logic [62:0]  s_wdata, s_rdata;
  ostp_ram #(.WIDTH(63), .DEPTH(N)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic         f_we;
  logic [HW-1:0] f_wdata, f_rdata;
  ostp_ram #(.WIDTH(HW), .DEPTH(N)) u_fifo (
    .clk(clk), .we(f_we), .waddr(f_tail), .wdata(f_wdata),
    .raddr(f_head), .rdata(f_rdata)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // expiry of slot under evaluation
  logic [31:0] age;
  logic        expired;
  assign age     = cur_time - s_rdata[62:31];
  assign expired = eval_vld && live[eval_idx] && (age >= {1'b0, s_rdata[30:0]});

  // a new fired result needs the output to emit the held one
  logic hold;
  assign hold = (state == S_EVAL) && (op == ostp_pkg::OP_TICK) && expired &&
                have_pend && !out_free;

  // clear pushes the slot at eval_idx if live; tick pushes if expired
  logic clr_hit;
  assign clr_hit = eval_vld && live[eval_idx];
  logic push;
  assign push = (state == S_EVAL) && !hold &&
                ((op == ostp_pkg::OP_CLEAR) ? clr_hit : expired);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = fresh_cnt[HW-1:0];
    s_wdata = {cur_time, dly};
    s_raddr = hold ? eval_idx : scan_idx[HW-1:0]; // keep rdata while held
    f_we    = 1'b0;
    f_wdata = eval_idx;
    if (state == S_IDLE && in_xfer && operation == ostp_pkg::OP_DEFER && !fresh_ex) begin
      s_we    = 1'b1;
      s_wdata = {cur_time, delay_ms};
    end else if (state == S_POP) begin
      s_we    = 1'b1;
      s_waddr = f_rdata;
    end
    if (state == S_IDLE && in_xfer && operation == ostp_pkg::OP_CANCEL &&
        live[target_handle] && f_count < (HW+1)'(N)) begin
      f_we    = 1'b1;
      f_wdata = target_handle;
    end else if (push && f_count < (HW+1)'(N)) begin
      f_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      cur_time  <= '0;
      fresh_cnt <= '0;
      fresh_ex  <= 1'b0;
      f_head    <= '0;
      f_tail    <= '0;
      f_count   <= '0;
      out_valid <= 1'b0;
      eval_vld  <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (f_we) begin
        f_tail  <= f_tail + 1'b1;
        f_count <= f_count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op  <= operation;
            dly <= delay_ms;
            out_valid <= 1'b1;
            kind      <= ostp_pkg::KIND_DONE;
            handle    <= '0;
            last      <= 1'b1;
            case (operation)
              ostp_pkg::OP_DEFER: begin
                if (!fresh_ex) begin
                  live[fresh_cnt[HW-1:0]] <= 1'b1;
                  kind      <= ostp_pkg::KIND_GRANTED;
                  handle    <= fresh_cnt[HW-1:0];
                  fresh_cnt <= fresh_cnt + 1'b1;
                  if (fresh_cnt == (HW+1)'(N - 1)) fresh_ex <= 1'b1;
                end else if (f_count != '0) begin
                  out_valid <= 1'b0;
                  state     <= S_POP;
                end else begin
                  kind <= ostp_pkg::KIND_NO_HANDLE;
                end
              end
              ostp_pkg::OP_CANCEL: begin
                if (live[target_handle]) live[target_handle] <= 1'b0;
              end
              default: begin // clear and tick scan all slots
                out_valid <= 1'b0;
                if (operation == ostp_pkg::OP_TICK)
                  cur_time <= cur_time + {16'd0, elapsed_ms};
                scan_idx  <= '0;
                eval_vld  <= 1'b0;
                have_pend <= 1'b0;
                state     <= S_SCAN;
              end
            endcase
          end
        end
        S_POP: begin
          live[f_rdata] <= 1'b1;
          f_head    <= f_head + 1'b1;
          f_count   <= f_count - 1'b1 + (f_we ? 1'b1 : 1'b0);
          out_valid <= 1'b1;
          kind      <= ostp_pkg::KIND_GRANTED;
          handle    <= f_rdata;
          last      <= 1'b1;
          state     <= S_IDLE;
        end
        S_SCAN: begin
          // read of scan_idx issued this cycle
          eval_idx <= scan_idx[HW-1:0];
          eval_vld <= 1'b1;
          scan_idx <= scan_idx + 1'b1;
          state    <= S_EVAL;
        end
        S_EVAL: begin
          if (!hold) begin
            if (push) live[eval_idx] <= 1'b0;
            if (op == ostp_pkg::OP_TICK && expired) begin
              if (have_pend) begin
                out_valid <= 1'b1;
                kind      <= ostp_pkg::KIND_FIRED;
                handle    <= pend_h;
                last      <= 1'b0;
              end
              have_pend <= 1'b1;
              pend_h    <= eval_idx;
            end
            if (scan_idx == (HW+1)'(N)) begin
              eval_vld <= 1'b0;
              state    <= S_FLUSH;
            end else begin
              eval_idx <= scan_idx[HW-1:0];
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind      <= have_pend ? ostp_pkg::KIND_FIRED : ostp_pkg::KIND_DONE;
            handle    <= have_pend ? pend_h : '0;
            last      <= 1'b1;
            have_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/one_shot_timer_pool_with_handles_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_timer_pool_with_handles_top_test: self-checking bench for the pool
// Directed and random defer/cancel/clear/tick traffic. Each transfer is scored
// against an in-bench model of the pool, with random idling on both sides.
// ----------------------------------------------------------------------------
module one_shot_timer_pool_with_handles_top_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = ostp_pkg::OP_TICK;
  logic [30:0] delay_ms = '0;
  logic [5:0]  target_handle = '0;
  logic [15:0] elapsed_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [5:0]  handle;
  logic        last;

  one_shot_timer_pool_with_handles_top DUT (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] handle;
    logic       last;
  } answer_t;

  // Pool model state
  logic        live_q [ostp_pkg::NUM_SLOTS];
  logic [31:0] start_q [ostp_pkg::NUM_SLOTS];
  logic [30:0] dur_q [ostp_pkg::NUM_SLOTS];
  logic [31:0] now_q;
  int          fresh_q;
  logic        exhausted_q;
  logic [5:0]  freed_q [$];

  answer_t pending_answers [$];
  int  errors = 0;
  bit  calm = 0;       // no idling in the last part
  int  hold_off = 0;   // long receiver hold-off, in cycles
  int  stall_left = 0; // rest of a random receiver stall burst

  function automatic void free_handle(int h);
    if (freed_q.size() < ostp_pkg::NUM_SLOTS) freed_q.push_back(h[5:0]);
  endfunction

  // Work out the answers an accepted item causes
  function automatic void predict_pool(logic [1:0] op, logic [30:0] dly,
                                       logic [5:0] tgt, logic [15:0] ela);
    int h;
    int n;
    n = 0;
    case (op)
      ostp_pkg::OP_DEFER: begin
        if (!exhausted_q) begin
          h = fresh_q;
          fresh_q++;
          if (fresh_q >= ostp_pkg::NUM_SLOTS) exhausted_q = 1'b1;
        end else if (freed_q.size() > 0) begin
          h = freed_q.pop_front();
        end else begin
          h = -1;
        end
        if (h < 0) begin
          pending_answers.push_back('{ostp_pkg::KIND_NO_HANDLE, 6'd0, 1'b1});
        end else begin
          live_q[h] = 1'b1;
          start_q[h] = now_q;
          dur_q[h] = dly;
          pending_answers.push_back('{ostp_pkg::KIND_GRANTED, h[5:0], 1'b1});
        end
      end
      ostp_pkg::OP_CANCEL: begin
        if (tgt < ostp_pkg::NUM_SLOTS && live_q[tgt]) begin
          live_q[tgt] = 1'b0;
          free_handle(tgt);
        end
        pending_answers.push_back('{ostp_pkg::KIND_DONE, 6'd0, 1'b1});
      end
      ostp_pkg::OP_CLEAR: begin
        for (int i = 0; i < ostp_pkg::NUM_SLOTS; i++)
          if (live_q[i]) begin
            live_q[i] = 1'b0;
            free_handle(i);
          end
        pending_answers.push_back('{ostp_pkg::KIND_DONE, 6'd0, 1'b1});
      end
      default: begin
        now_q = now_q + ela;
        for (int i = 0; i < ostp_pkg::NUM_SLOTS; i++)
          if (live_q[i] && (now_q - start_q[i]) >= {1'b0, dur_q[i]}) begin
            live_q[i] = 1'b0;
            free_handle(i);
            pending_answers.push_back('{ostp_pkg::KIND_FIRED, i[5:0], 1'b0});
            n++;
          end
        if (n == 0) pending_answers.push_back('{ostp_pkg::KIND_DONE, 6'd0, 1'b1});
        else pending_answers[$].last = 1'b1;
      end
    endcase
  endfunction

  // Send one item; random gap first unless in the calm part
  task automatic send_item(logic [1:0] op, logic [30:0] dly = '0,
                           logic [5:0] tgt = '0, logic [15:0] ela = '0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    delay_ms <= dly;
    target_handle <= tgt;
    elapsed_ms <= ela;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pool(op, dly, tgt, ela);
  endtask

  // Receiver stall pattern: long hold-off, or random stall bursts
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (calm) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 14));
    end else out_stall <= 1'b0;
  end

  // Scoreboard: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result kind=%0d handle=%0d last=%0d",
                 $time, kind, handle, last);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
          errors++;
        end
        if (handle !== want.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, want.handle, handle);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  function automatic logic [30:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 400));
    endcase
  endfunction

  // Directed: extremes, no-handle, cancel of dead handle, zero-tick expiry
  task automatic test_directed();
    send_item(ostp_pkg::OP_TICK, '0, '0, 16'd0);
    send_item(ostp_pkg::OP_DEFER, 31'd0);
    send_item(ostp_pkg::OP_DEFER, 31'h7FFF_FFFF);
    send_item(ostp_pkg::OP_DEFER, 31'd5);
    send_item(ostp_pkg::OP_TICK, '0, '0, 16'd0);     // zero delay fires on zero tick
    send_item(ostp_pkg::OP_CANCEL, '0, 6'd0);         // already freed
    send_item(ostp_pkg::OP_CANCEL, '0, 6'd63);        // never live
    send_item(ostp_pkg::OP_CANCEL, '0, 6'd1);
    send_item(ostp_pkg::OP_TICK, '0, '0, 16'hFFFF);
    send_item(ostp_pkg::OP_CLEAR);
    for (int i = 0; i < 61; i++) send_item(ostp_pkg::OP_DEFER, 31'd3);  // exhaust fresh
    send_item(ostp_pkg::OP_DEFER, 31'd2);             // reuse of freed handles
    send_item(ostp_pkg::OP_DEFER, 31'd2);
    send_item(ostp_pkg::OP_DEFER, 31'd2);
    send_item(ostp_pkg::OP_DEFER, 31'd2);             // FIFO empty: no handle
    send_item(ostp_pkg::OP_TICK, '0, '0, 16'd4);      // all 64 fire
  endtask

  // Receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 10; i++) send_item(ostp_pkg::OP_DEFER, 31'd1);
    send_item(ostp_pkg::OP_TICK, '0, '0, 16'd2);
  endtask

  // Random mix, mostly defers and ticks so timers live and expire
  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i > count * 3 / 4) calm = 1;
      r = $urandom_range(0, 19);
      if (r < 9)
        send_item(ostp_pkg::OP_DEFER, pick_delay(), 6'($urandom), 16'($urandom));
      else if (r < 12)
        send_item(ostp_pkg::OP_CANCEL, pick_delay(), 6'($urandom), 16'($urandom));
      else if (r < 13)
        send_item(ostp_pkg::OP_CLEAR, pick_delay(), 6'($urandom), 16'($urandom));
      else send_item(ostp_pkg::OP_TICK, pick_delay(), 6'($urandom),
                     ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 200)));
    end
  endtask

  initial begin
    for (int i = 0; i < ostp_pkg::NUM_SLOTS; i++) begin
      live_q[i] = 1'b0;
      start_q[i] = '0;
      dur_q[i] = '0;
    end
    now_q = '0;
    fresh_q = 0;
    exhausted_q = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(135);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (ostp_pkg::NUM_SLOTS + 10) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

[sim.f]
rtl/ostp_pkg.sv
rtl/ostp_ram.sv
rtl/one_shot_timer_pool_with_handles_top.sv
tb/one_shot_timer_pool_with_handles_top_test.sv
